// ===== src/scalar_depth_kalman_correct_assert.svh =====
// Assertion macros for the depth correction block.
`ifndef SCALAR_DEPTH_KALMAN_CORRECT_ASSERT_SVH
`define SCALAR_DEPTH_KALMAN_CORRECT_ASSERT_SVH

// Holds at every edge outside reset.
`define SDKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SDKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sdkc_pkg.sv =====
// Shared constants, types and helpers for the depth correction block.
package sdkc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_NOISE_DENS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RAND_WALK  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIGMA      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VEL_ON     = 3'd4;

  localparam logic [31:0] NOISE_DENS_RST = 32'd167772;
  localparam logic [31:0] RAND_WALK_RST  = 32'd16777;
  localparam logic [31:0] SIGMA_RST      = 32'd1677722;
  localparam logic [30:0] THRESHOLD_RST  = 31'd655;
  localparam logic [31:0] VARIANCE_RST   = 32'd167772;

  localparam logic [24:0] ONE_Q24    = 25'h1000000;
  localparam logic [31:0] MIN_DT_Q24 = 32'd167772;
  localparam logic [33:0] DIV_THREE  = 34'd3;
  localparam logic [33:0] DIV_TWENTY = 34'd20;

  typedef struct packed {
    logic start;
    logic raw;
  } mul_ctl_t;

  function automatic logic [31:0] sat_s32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (x < -66'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== src/sdkc_if.sv =====
// Item channel interfaces: measurement items in, corrected results out.
interface sdkc_item_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] predicted_depth;
  logic [31:0] vertical_velocity;
  logic [31:0] measured_depth;
  logic [31:0] time_step;
  modport source (output valid, func, predicted_depth, vertical_velocity, measured_depth,
                  time_step, input ready);
  modport sink (input valid, func, predicted_depth, vertical_velocity, measured_depth,
                time_step, output ready);
endinterface

interface sdkc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] corrected_depth;
  logic [31:0] corrected_velocity;
  logic [31:0] innovation;
  logic [31:0] variance_now;
  logic        applied;
  modport source (output valid, corrected_depth, corrected_velocity, innovation,
                  variance_now, applied, input ready);
  modport sink (input valid, corrected_depth, corrected_velocity, innovation,
                variance_now, applied, output ready);
endinterface

// ===== src/scalar_depth_kalman_correct.sv =====
// Scalar depth Kalman correction top level: config regs, sequencer, shared mul/div.
// Sequence: a restart or below-threshold item needs only the sigma-squared multiply; a
// correction runs 14 or 15 multiplies and 2 to 4 divides on the shared units.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: config registers take their defaults, depth variance reloads 167772.
module scalar_depth_kalman_correct import sdkc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  sdkc_item_if.sink           item_i,
  sdkc_result_if.source       result_o
);

  `include "scalar_depth_kalman_correct_assert.svh"

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_R    = 5'd1;
  localparam logic [4:0] ST_T1   = 5'd2;
  localparam logic [4:0] ST_A1   = 5'd3;
  localparam logic [4:0] ST_A2   = 5'd4;
  localparam logic [4:0] ST_D3   = 5'd5;
  localparam logic [4:0] ST_T2   = 5'd6;
  localparam logic [4:0] ST_B1   = 5'd7;
  localparam logic [4:0] ST_C1   = 5'd8;
  localparam logic [4:0] ST_C2   = 5'd9;
  localparam logic [4:0] ST_B2   = 5'd10;
  localparam logic [4:0] ST_D20  = 5'd11;
  localparam logic [4:0] ST_K    = 5'd12;
  localparam logic [4:0] ST_CORR = 5'd13;
  localparam logic [4:0] ST_VM   = 5'd14;
  localparam logic [4:0] ST_VD   = 5'd15;
  localparam logic [4:0] ST_X1   = 5'd16;
  localparam logic [4:0] ST_X2   = 5'd17;
  localparam logic [4:0] ST_Y1   = 5'd18;
  localparam logic [4:0] ST_Y2   = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  logic [31:0] noise_dens_q, rand_walk_q, sigma_q;
  logic [30:0] thr_q;
  logic        vel_on_q;
  logic [31:0] var_q;

  logic [4:0]  state_q, state_d;
  logic        issued_q;

  logic        func_q, neg_q;
  logic [31:0] pred_q, vel_q, dt_q;
  logic signed [32:0] inn_q;
  logic [32:0] mag_q;
  logic [31:0] r_q, pp_q;
  logic [63:0] tmp_q, tmp2_q, nb_q;
  logic [24:0] k_q;
  logic [31:0] depth_q, velo_q;
  logic        applied_q;

  logic        out_valid_q;
  logic [31:0] out_depth_q, out_velo_q, out_inn_q, out_var_q;
  logic        out_applied_q;

  logic        in_acc, is_mul, is_div, step_done, mul_raw, out_load;
  logic [63:0] mul_a, mul_b, mul_res, div_num, div_q;
  logic [33:0] div_den, div_r;
  logic        mul_busy, mul_done, div_busy, div_done;
  mul_ctl_t    mul_ctl;

  logic signed [32:0] inn_d;
  logic [32:0] mag_d;
  logic [31:0] r_new, pp_new, dte, pn, var_new;
  logic        rnd;
  logic [63:0] nq;
  logic [65:0] sum_pp;
  logic [32:0] den;
  logic [24:0] omk;
  logic [64:0] pn_sum;
  logic signed [65:0] depth_sum, velo_sum;

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_dens_q <= NOISE_DENS_RST;
      rand_walk_q  <= RAND_WALK_RST;
      sigma_q      <= SIGMA_RST;
      thr_q        <= THRESHOLD_RST;
      vel_on_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NOISE_DENS: noise_dens_q <= cfg_data_i;
        CFG_RAND_WALK:  rand_walk_q  <= cfg_data_i;
        CFG_SIGMA:      sigma_q      <= cfg_data_i;
        CFG_THRESHOLD:  thr_q        <= cfg_data_i[30:0];
        CFG_VEL_ON:     vel_on_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath helpers ----------------
  assign in_acc = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);

  assign inn_d = $signed({item_i.measured_depth[31], item_i.measured_depth})
               - $signed({item_i.predicted_depth[31], item_i.predicted_depth});
  assign mag_d = inn_d[32] ? 33'(-inn_d) : inn_d;

  assign r_new  = (|mul_res[63:32]) ? '1 : mul_res[31:0];
  assign rnd    = ({div_r, 1'b0} >= {1'b0, div_den});
  assign nq     = div_q + {63'd0, rnd};
  assign sum_pp = {34'd0, var_q} + {2'd0, nb_q} + {2'd0, nq};
  assign pp_new = (|sum_pp[65:32]) ? '1 : sum_pp[31:0];
  assign den    = {1'b0, pp_q} + {1'b0, r_q};
  assign dte    = (dt_q < MIN_DT_Q24) ? MIN_DT_Q24 : dt_q;
  assign omk    = ONE_Q24 - k_q;
  assign pn_sum = {1'b0, tmp_q} + {1'b0, mul_res};
  assign pn     = (|pn_sum[64:32]) ? '1 : pn_sum[31:0];
  assign var_new = (pn < r_q) ? r_q : pn;

  assign depth_sum = $signed({{34{pred_q[31]}}, pred_q})
                   + (neg_q ? -$signed({2'd0, mul_res}) : $signed({2'd0, mul_res}));
  assign velo_sum  = $signed({{34{vel_q[31]}}, vel_q})
                   + (neg_q ? -$signed({2'd0, div_q}) : $signed({2'd0, div_q}));

  // operand selection for the shared units
  always_comb begin
    mul_a   = 64'd0;
    mul_b   = 64'd0;
    mul_raw = 1'b0;
    div_num = tmp_q;
    div_den = DIV_THREE;
    is_mul  = 1'b1;
    is_div  = 1'b0;
    case (state_q)
      ST_R:    begin mul_a = {32'd0, sigma_q};      mul_b = {32'd0, sigma_q}; end
      ST_T1:   begin mul_a = {32'd0, noise_dens_q}; mul_b = {32'd0, dt_q}; end
      ST_A1:   begin mul_a = tmp_q;                 mul_b = tmp_q; end
      ST_A2:   begin mul_a = tmp_q;                 mul_b = {32'd0, dt_q}; end
      ST_T2:   begin mul_a = {32'd0, rand_walk_q};  mul_b = {32'd0, dt_q}; end
      ST_B1:   begin mul_a = tmp_q;                 mul_b = tmp_q; end
      ST_C1:   begin mul_a = {32'd0, dt_q};         mul_b = {32'd0, dt_q}; end
      ST_C2:   begin mul_a = tmp2_q;                mul_b = {32'd0, dt_q}; end
      ST_B2:   begin mul_a = tmp_q;                 mul_b = tmp2_q; end
      ST_CORR: begin mul_a = {31'd0, mag_q};        mul_b = {39'd0, k_q}; end
      ST_VM:   begin mul_a = {31'd0, mag_q};        mul_b = {39'd0, k_q}; mul_raw = 1'b1; end
      ST_X1:   begin mul_a = {39'd0, omk};          mul_b = {39'd0, omk}; end
      ST_X2:   begin mul_a = tmp_q;                 mul_b = {32'd0, pp_q}; end
      ST_Y1:   begin mul_a = {39'd0, k_q};          mul_b = {39'd0, k_q}; end
      ST_Y2:   begin mul_a = tmp2_q;                mul_b = {32'd0, r_q}; end
      ST_D3:   begin is_mul = 1'b0; is_div = 1'b1; end
      ST_D20:  begin is_mul = 1'b0; is_div = 1'b1; div_den = DIV_TWENTY; end
      ST_K: begin
        is_mul  = 1'b0;
        is_div  = 1'b1;
        div_num = {8'd0, pp_q, 24'd0} + {32'd0, den[32:1]};
        div_den = {1'b0, den};
      end
      ST_VD: begin
        is_mul  = 1'b0;
        is_div  = 1'b1;
        div_den = {1'b0, dte, 1'b0};
      end
      default: begin is_mul = 1'b0; end
    endcase
  end

  assign mul_ctl.start = is_mul && !issued_q;
  assign mul_ctl.raw   = mul_raw;
  assign step_done     = mul_done || div_done;
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || result_o.ready);

  sdkc_mul u_mul (
    .clk_i, .rst_ni,
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  sdkc_div u_div (
    .clk_i, .rst_ni,
    .start_i (is_div && !issued_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_R;
      ST_R: if (step_done) begin
        if (func_q || (mag_q < {2'd0, thr_q})) state_d = ST_OUT;
        else state_d = ST_T1;
      end
      ST_T1:  if (step_done) state_d = ST_A1;
      ST_A1:  if (step_done) state_d = ST_A2;
      ST_A2:  if (step_done) state_d = ST_D3;
      ST_D3:  if (step_done) state_d = ST_T2;
      ST_T2:  if (step_done) state_d = ST_B1;
      ST_B1:  if (step_done) state_d = ST_C1;
      ST_C1:  if (step_done) state_d = ST_C2;
      ST_C2:  if (step_done) state_d = ST_B2;
      ST_B2:  if (step_done) state_d = ST_D20;
      ST_D20: if (step_done) begin
        // both variances zero: gain is zero, skip the divide
        state_d = (pp_new == 32'd0 && r_q == 32'd0) ? ST_CORR : ST_K;
      end
      ST_K:    if (step_done) state_d = ST_CORR;
      ST_CORR: if (step_done) state_d = vel_on_q ? ST_VM : ST_X1;
      ST_VM:   if (step_done) state_d = ST_VD;
      ST_VD:   if (step_done) state_d = ST_X1;
      ST_X1:   if (step_done) state_d = ST_X2;
      ST_X2:   if (step_done) state_d = ST_Y1;
      ST_Y1:   if (step_done) state_d = ST_Y2;
      ST_Y2:   if (step_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      var_q       <= VARIANCE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step_done) issued_q <= 1'b0;
      else if (is_mul || is_div) issued_q <= 1'b1;
      if (state_q == ST_R && step_done && func_q) var_q <= r_new;
      if (state_q == ST_Y2 && step_done) var_q <= var_new;
      if (out_load) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= item_i.func;
      pred_q    <= item_i.predicted_depth;
      vel_q     <= item_i.vertical_velocity;
      dt_q      <= item_i.time_step;
      inn_q     <= inn_d;
      neg_q     <= inn_d[32];
      mag_q     <= mag_d;
      depth_q   <= item_i.predicted_depth;
      velo_q    <= item_i.vertical_velocity;
      applied_q <= 1'b0;
    end
    if (step_done) begin
      case (state_q)
        ST_R:  r_q <= r_new;
        ST_T1, ST_A1, ST_A2, ST_T2, ST_B1, ST_B2, ST_X1, ST_X2: tmp_q <= mul_res;
        ST_C1, ST_C2, ST_Y1: tmp2_q <= mul_res;
        ST_D3: nb_q <= nq;
        ST_D20: begin
          pp_q <= pp_new;
          k_q  <= 25'd0;
        end
        ST_K:    k_q <= div_q[24:0];
        ST_CORR: depth_q <= sat_s32(depth_sum);
        ST_VM:   tmp_q <= mul_res + {32'd0, dte};
        ST_VD:   velo_q <= sat_s32(velo_sum);
        ST_Y2:   applied_q <= 1'b1;
        default: ;
      endcase
    end
    if (out_load) begin
      out_depth_q   <= depth_q;
      out_velo_q    <= velo_q;
      out_inn_q     <= func_q ? 32'd0 : sat_s32({{33{inn_q[32]}}, inn_q});
      out_var_q     <= var_q;
      out_applied_q <= applied_q;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.corrected_depth    = out_depth_q;
  assign result_o.corrected_velocity = out_velo_q;
  assign result_o.innovation         = out_inn_q;
  assign result_o.variance_now       = out_var_q;
  assign result_o.applied            = out_applied_q;

  `SDKC_ASSERT(a_units_exclusive, !(mul_busy && div_busy), "mul and div busy together")
  `SDKC_ASSERT_NEXT(a_accept_blocks, in_acc, !item_i.ready, "ready after accepting an item")
  `SDKC_ASSERT(a_idle_quiet, item_i.ready |-> (!mul_busy && !div_busy), "unit busy while idle")
  `SDKC_ASSERT(a_done_in_step, step_done |-> (state_q != ST_IDLE && state_q != ST_OUT),
               "unit finished outside a compute step")

endmodule

// ===== src/sdkc_mul.sv =====
// 64x64 multiplier built from one 32x32 multiplier in four steps, Q.24 round/saturate unless raw.
module sdkc_mul import sdkc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_ctl_t    ctl_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q, raw_q;
  logic [31:0]  a_half, b_half;
  logic [63:0]  prod;
  logic [6:0]   sh;

  assign a_half = cnt_q[1] ? a_i[63:32] : a_i[31:0];
  assign b_half = cnt_q[0] ? b_i[63:32] : b_i[31:0];
  assign prod   = a_half * b_half;
  assign sh     = {({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]}), 5'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
      raw_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
        raw_q  <= ctl_i.raw;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // in rounded mode the rounding half is preloaded so the final sum is already rounded
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) acc_q <= ctl_i.raw ? 128'd0 : 128'h80_0000;
    else if (busy_q) acc_q <= acc_q + ({64'd0, prod} << sh);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = raw_q ? acc_q[63:0] : ((|acc_q[127:88]) ? '1 : acc_q[87:24]);

endmodule

// ===== src/sdkc_div.sv =====
// Restoring divider, 64-bit dividend by 34-bit divisor, one quotient bit per cycle.
module sdkc_div import sdkc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [33:0] rem_o
);

  logic [63:0] quo_q;
  logic [33:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [34:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= 34'd0;
    end else if (busy_q) begin
      if (!trial[34]) rem_q <= trial[33:0];
      else rem_q <= {rem_q[32:0], quo_q[63]};
      quo_q <= {quo_q[62:0], ~trial[34]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sim/scalar_depth_kalman_correct_tb.sv =====
// Testbench for the scalar depth Kalman correction block: predictor, stimulus and checks.
module scalar_depth_kalman_correct_tb;
  import sdkc_pkg::*;

  typedef struct packed {
    logic [31:0] depth;
    logic [31:0] velocity;
    logic [31:0] innovation;
    logic [31:0] variance;
    logic        applied;
  } depth_fix_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  sdkc_item_if   item_bus();
  sdkc_result_if res_bus();

  scalar_depth_kalman_correct dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (item_bus),
    .result_o  (res_bus)
  );

  // Register mirror and filter state.
  logic [31:0] noise_dens, rand_walk, sigma;
  logic [30:0] thresh;
  logic        vel_on;
  logic [31:0] variance_st;

  depth_fix_t  pending_fixes[$];
  int unsigned fail_count, items_sent, fixes_seen, corrections_seen, restarts_sent;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("FAIL scalar_depth_kalman_correct");
    $finish;
  end

  function automatic logic [63:0] q24_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + 128'h80_0000;
    if (p[127:88] != '0) return '1;
    return p[87:24];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] round_div(input logic [63:0] x, input logic [63:0] d);
    return x / d + ((((x % d) << 1) >= d) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [31:0] clip_u32(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic [31:0] clip_s32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] baro_var();
    return clip_u32(q24_mul({32'd0, sigma}, {32'd0, sigma}));
  endfunction

  // Expected result for one item; advances the variance state.
  function automatic depth_fix_t kalman_correct(input logic fn, input logic [31:0] pred,
                                                input logic [31:0] vel, input logic [31:0] meas,
                                                input logic [31:0] dt);
    depth_fix_t f;
    longint inn, p, v;
    logic [63:0] mag, r, t1, noise, t2, dt3, bias, pp, den, k, corr, omk, pn, dte, vc;
    logic neg;
    r = {32'd0, baro_var()};
    p = longint'(signed'(pred));
    v = longint'(signed'(vel));
    f.depth = pred;
    f.velocity = vel;
    f.applied = 1'b0;
    if (fn) begin
      variance_st = r[31:0];
      f.innovation = '0;
      f.variance = variance_st;
      return f;
    end
    inn = longint'(signed'(meas)) - p;
    neg = inn < 0;
    mag = neg ? -inn : inn;
    if (mag >= {33'd0, thresh}) begin
      t1 = q24_mul({32'd0, noise_dens}, {32'd0, dt});
      noise = round_div(q24_mul(q24_mul(t1, t1), {32'd0, dt}), 64'd3);
      t2 = q24_mul({32'd0, rand_walk}, {32'd0, dt});
      dt3 = q24_mul(q24_mul({32'd0, dt}, {32'd0, dt}), {32'd0, dt});
      bias = round_div(q24_mul(q24_mul(t2, t2), dt3), 64'd20);
      pp = {32'd0, clip_u32(sat_add({32'd0, variance_st}, sat_add(noise, bias)))};
      den = pp + r;
      k = (den == 0) ? 64'd0 : ((pp << 24) + den / 2) / den;
      corr = (mag * k + 64'h80_0000) >> 24;
      omk = 64'h100_0000 - k;
      f.depth = clip_s32(neg ? p - longint'(corr) : p + longint'(corr));
      if (vel_on) begin
        dte = (dt < MIN_DT_Q24) ? {32'd0, MIN_DT_Q24} : {32'd0, dt};
        vc = (mag * k + dte) / (2 * dte);
        f.velocity = clip_s32(neg ? v - longint'(vc) : v + longint'(vc));
      end
      pn = {32'd0, clip_u32(sat_add(q24_mul(q24_mul(omk, omk), pp),
                                    q24_mul(q24_mul(k, k), r)))};
      variance_st = (pn < r) ? r[31:0] : pn[31:0];
      f.applied = 1'b1;
    end
    f.innovation = clip_s32(inn);
    f.variance = variance_st;
    return f;
  endfunction

  // Result receiver: random stalls, checks against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk_i) begin
    depth_fix_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      fixes_seen++;
      if (pending_fixes.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (want.applied) corrections_seen++;
        if (res_bus.corrected_depth !== want.depth) begin
          $error("corrected_depth exp %0h got %0h", want.depth, res_bus.corrected_depth);
          fail_count++;
        end
        if (res_bus.corrected_velocity !== want.velocity) begin
          $error("corrected_velocity exp %0h got %0h", want.velocity,
                 res_bus.corrected_velocity);
          fail_count++;
        end
        if (res_bus.innovation !== want.innovation) begin
          $error("innovation exp %0h got %0h", want.innovation, res_bus.innovation);
          fail_count++;
        end
        if (res_bus.variance_now !== want.variance) begin
          $error("variance_now exp %0h got %0h", want.variance, res_bus.variance_now);
          fail_count++;
        end
        if (res_bus.applied !== want.applied) begin
          $error("applied exp %0b got %0b", want.applied, res_bus.applied);
          fail_count++;
        end
      end
    end
  end

  task automatic send_meas(input logic fn, input logic [31:0] pred, input logic [31:0] vel,
                           input logic [31:0] meas, input logic [31:0] dt);
    while (!calm && $urandom_range(99) < 32) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid             <= 1'b1;
    item_bus.func              <= fn;
    item_bus.predicted_depth   <= pred;
    item_bus.vertical_velocity <= vel;
    item_bus.measured_depth    <= meas;
    item_bus.time_step         <= dt;
    do @(posedge clk_i); while (!item_bus.ready);
    pending_fixes.push_back(kalman_correct(fn, pred, vel, meas, dt));
    items_sent++;
    if (fn) restarts_sent++;
  endtask

  // Lets the block go idle before a register write.
  task automatic drain();
    item_bus.valid <= 1'b0;
    wait (pending_fixes.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NOISE_DENS: noise_dens = val;
      CFG_RAND_WALK:  rand_walk = val;
      CFG_SIGMA:      sigma = val;
      CFG_THRESHOLD:  thresh = val[30:0];
      CFG_VEL_ON:     vel_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] n, input logic [31:0] w, input logic [31:0] s,
                          input logic [31:0] th, input logic [31:0] von);
    write_reg(CFG_NOISE_DENS, n);
    write_reg(CFG_RAND_WALK, w);
    write_reg(CFG_SIGMA, s);
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_VEL_ON, von);
  endtask

  task automatic test_directed();
    // Reset settings: pass-through, threshold edge, innovation extremes, and a restart.
    send_meas(1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0100_0000);
    send_meas(1'b0, 32'd0, 32'd5, 32'd654, 32'h0100_0000);
    send_meas(1'b0, 32'd0, 32'd5, 32'd655, 32'h0100_0000);
    send_meas(1'b0, 32'd0, 32'd5, -32'sd655, 32'h0100_0000);
    send_meas(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_meas(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_meas(1'b1, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // Velocity correction on, an unused register index written, time steps at and below the minimum.
    write_reg(CFG_VEL_ON, 32'd1);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_meas(1'b0, 32'h0000_0000, 32'h7FFF_0000, 32'h0100_0000, 32'd1);
    send_meas(1'b0, 32'h0000_0000, 32'h8000_1000, 32'hFF00_0000, 32'd167771);
    send_meas(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'd167772);
    send_meas(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    drain();
    // Zero sigma and zero noise: restart leaves P at zero, gain goes to zero.
    set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    send_meas(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_meas(1'b0, 32'd100, 32'd7, 32'd100, 32'h0100_0000);
    send_meas(1'b0, 32'd100, 32'd7, 32'd900, 32'h0100_0000);
    drain();
    // All-ones settings: saturating noise and variance.
    set_regs('1, '1, '1, 32'h7FFF_FFFF, 32'd1);
    send_meas(1'b0, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_meas(1'b0, 32'd0, 32'd0, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    send_meas(1'b1, 32'd3, 32'd4, 32'd5, 32'd6);
    send_meas(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0800_0000);
    drain();
  endtask

  task automatic random_regs();
    logic [31:0] n, w, s, th;
    n  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(32'h0200_0000);
    w  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(32'h0080_0000);
    s  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(32'h0400_0000);
    th = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(32'h0004_0000);
    set_regs(n, w, s, th, $urandom_range(1));
  endtask

  task automatic test_random(input int unsigned count);
    logic [31:0] pred, meas, dt, dev;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        drain();
        random_regs();
      end
      calm = (i % 200) >= 150 && (i % 200) < 180;
      pred = $urandom();
      case ($urandom_range(9))
        0, 1, 2, 3: dev = $urandom_range(2 * thresh + 16);
        4, 5, 6:    dev = $urandom_range(32'h0100_0000);
        default:    dev = $urandom();
      endcase
      meas = $urandom_range(1) ? pred + dev : pred - dev;
      if ($urandom_range(9) == 0) meas = $urandom();
      case ($urandom_range(9))
        0:       dt = $urandom_range(167772);
        1, 2:    dt = $urandom();
        default: dt = $urandom_range(32'h0400_0000);
      endcase
      send_meas($urandom_range(19) == 0, pred, $urandom(), meas, dt);
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    item_bus.valid = 1'b0;
    item_bus.func = 1'b0;
    item_bus.predicted_depth = '0;
    item_bus.vertical_velocity = '0;
    item_bus.measured_depth = '0;
    item_bus.time_step = '0;
    calm = 1'b0;
    fail_count = 0;
    items_sent = 0;
    fixes_seen = 0;
    corrections_seen = 0;
    restarts_sent = 0;
    noise_dens = NOISE_DENS_RST;
    rand_walk = RAND_WALK_RST;
    sigma = SIGMA_RST;
    thresh = THRESHOLD_RST;
    vel_on = 1'b0;
    variance_st = VARIANCE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(1680);

    if (pending_fixes.size() != 0) fail_count++;
    $display("covered %0d items (%0d restarts), %0d results, %0d corrections applied",
             items_sent, restarts_sent, fixes_seen, corrections_seen);
    $display("register settings swept from all-zero to all-ones across random phases");
    if (fail_count == 0) begin
      $display("PASS scalar_depth_kalman_correct");
    end else begin
      $display("FAIL scalar_depth_kalman_correct");
    end
    $finish;
  end

endmodule
